// ===== hw/rtl/tsr_pkg.sv =====
// ============================================================================
// tsr_pkg: shared definitions for the timestamped sample ring
// Default sizes, item kind codes, command codes and back-end states.
// ============================================================================
package tsr_pkg;

    localparam int RING_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_BLOCK_DEF   = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int TS_W  = 32;
    localparam int LEN_W = 7;
    localparam int OUT_W = 16;

    localparam logic [TS_W-1:0] HALF_RANGE = 32'h8000_0000;

    // Input item kinds.
    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } cmd_op_t;

    // Control part of a command passed from the front end to the back end.
    typedef struct packed {
        cmd_op_t op;
        logic    clr_en;
        logic    wr_en;
        logic    win_en;
    } cmd_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CLEAR = 2'd1,
        ST_WRITE = 2'd2,
        ST_GET   = 2'd3
    } back_state_t;

endpackage

// ===== hw/rtl/timestamped_sample_ring.sv =====
// ============================================================================
// timestamped_sample_ring: timestamp-indexed circular jitter buffer
// Stores put blocks at their timestamps modulo the ring depth and answers
// get requests with windowed samples, zero outside the valid window.
// ============================================================================
//
//  Channel   Direction  Beat contents                         Handshake
//  -------   ---------  ------------------------------------  ---------------
//  s_*       in         kind, ts, length, sample, first       s_valid/s_ready
//  m_*       out        sample_out, last                      m_valid/m_ready
//
// A put beat that only writes a sample is written by the back end directly
// from the idle state. The first beat of a put block that opens a gap passes
// through the idle dispatch, the clear sweep over the gap's slots (RING_DEPTH
// slots for a gap of a full ring or more and for the first put after reset),
// and the write state for its own sample. A get of N samples holds the back
// end from its dispatch through N reads in the get state, each read stalled
// while a result beat waits with m_ready low and registered as the next beat.
// Reset is synchronous and active low; it clears the newest mark and block
// state, while the ring memory is swept clean by the first put.
// The input side keeps accepting beats while the four-entry command queue has
// room, so a stalled result beat only holds the input once the queue fills.
//
// The front end owns the newest mark and decides drops and clears at the beat
// that carries the block start; it hands the back end self-contained
// commands. Every get carries a snapshot of its distance to the newest mark,
// so the back end never needs the front end's state.

module timestamped_sample_ring #(
    parameter int RING_DEPTH  = tsr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = tsr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = tsr_pkg::MAX_BLOCK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [tsr_pkg::TS_W-1:0]      s_ts,
    input  logic [tsr_pkg::LEN_W-1:0]     s_length,
    input  logic signed [15:0]            s_sample,
    input  logic                          s_first,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_sample_out,
    output logic                          m_last
);

    localparam int AW = $clog2(RING_DEPTH);

    // One queued command: control flags plus every operand either side needs.
    typedef struct packed {
        tsr_pkg::cmd_ctl_t               ctl;
        logic [AW-1:0]                   base;
        logic [AW-1:0]                   waddr;
        logic [AW:0]                     cnt;
        logic [SAMPLE_BITS-1:0]          wdata;
        logic [tsr_pkg::LEN_W-1:0]       len;
        logic [tsr_pkg::TS_W-1:0]        age;
    } cmd_t;

    cmd_t q_in, q_out;
    logic q_push, q_not_full, q_pop, q_not_empty;

    tsr_front #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK),
        .AW          (AW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_ts       (s_ts),
        .s_length   (s_length),
        .s_sample   (s_sample),
        .s_first    (s_first),
        .q_not_full (q_not_full),
        .q_push     (q_push),
        .c_ctl      (q_in.ctl),
        .c_base     (q_in.base),
        .c_waddr    (q_in.waddr),
        .c_cnt      (q_in.cnt),
        .c_wdata    (q_in.wdata),
        .c_len      (q_in.len),
        .c_age      (q_in.age)
    );

    tsr_queue #(
        .W     ($bits(cmd_t)),
        .DEPTH (tsr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    tsr_back #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .c_ctl        (q_out.ctl),
        .c_base       (q_out.base),
        .c_waddr      (q_out.waddr),
        .c_cnt        (q_out.cnt),
        .c_wdata      (q_out.wdata),
        .c_len        (q_out.len),
        .c_age        (q_out.age),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_last       (m_last)
    );

endmodule

// ===== hw/rtl/tsr_queue.sv =====
// ============================================================================
// tsr_queue: short command queue
// Register-based first-in first-out buffer between the front and back ends.
// ============================================================================
module tsr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = tsr_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         not_full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tsr_front.sv =====
// ============================================================================
// tsr_front: item classifier
// Keeps the newest mark and block state, decides drops and gap clears, and
// turns each input item into a command for the back end.
// ============================================================================
module tsr_front #(
    parameter int RING_DEPTH  = tsr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = tsr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = tsr_pkg::MAX_BLOCK_DEF,
    parameter int AW          = $clog2(RING_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [tsr_pkg::TS_W-1:0]      s_ts,
    input  logic [tsr_pkg::LEN_W-1:0]     s_length,
    input  logic signed [15:0]            s_sample,
    input  logic                          s_first,
    input  logic                          q_not_full,
    output logic                          q_push,
    output tsr_pkg::cmd_ctl_t             c_ctl,
    output logic [AW-1:0]                 c_base,
    output logic [AW-1:0]                 c_waddr,
    output logic [AW:0]                   c_cnt,
    output logic [SAMPLE_BITS-1:0]        c_wdata,
    output logic [tsr_pkg::LEN_W-1:0]     c_len,
    output logic [tsr_pkg::TS_W-1:0]      c_age
);

    localparam logic [tsr_pkg::TS_W-1:0]  DEPTH_TS = tsr_pkg::TS_W'(RING_DEPTH);
    localparam logic [tsr_pkg::LEN_W-1:0] MAX_LEN  = tsr_pkg::LEN_W'(MAX_BLOCK);

    logic                        started_reg, started_next;
    logic [tsr_pkg::TS_W-1:0]    newest_reg, newest_next;
    logic                        acc_reg, acc_next;
    logic [tsr_pkg::LEN_W-1:0]   off_reg, off_next;

    logic                        accept;
    logic [tsr_pkg::LEN_W-1:0]   len_sat;
    logic [tsr_pkg::TS_W-1:0]    len_ts;
    logic [tsr_pkg::TS_W-1:0]    nst;
    logic [tsr_pkg::TS_W-1:0]    drop_rel, gap, open_rel, end_rel, end_ts;
    logic                        dropped, gap_open, advance, gap_full;
    logic                        is_get, clr_en, acc_eff, wr_en;
    logic [tsr_pkg::LEN_W-1:0]   off_eff;
    logic [SAMPLE_BITS+15:0]     sample_ext;

    assign s_ready = q_not_full;
    assign accept  = s_valid && s_ready;
    assign is_get  = (s_kind == tsr_pkg::KIND_GET);

    assign len_sat = (s_length > MAX_LEN) ? MAX_LEN : s_length;
    assign len_ts  = {{(tsr_pkg::TS_W - tsr_pkg::LEN_W){1'b0}}, len_sat};

    // Before the first put the block start itself becomes the newest mark.
    assign nst      = started_reg ? newest_reg : s_ts;
    assign drop_rel = s_ts - nst + DEPTH_TS;
    assign dropped  = (drop_rel > tsr_pkg::HALF_RANGE);
    assign gap      = s_ts - nst;
    assign open_rel = nst - s_ts;
    assign gap_open = (open_rel > tsr_pkg::HALF_RANGE);
    assign end_rel  = nst - s_ts - len_ts;
    assign advance  = (end_rel > tsr_pkg::HALF_RANGE);
    assign end_ts   = s_ts + len_ts;
    assign gap_full = !started_reg || (gap[tsr_pkg::TS_W-1:AW] != '0);

    assign clr_en  = s_first && (!started_reg || (!dropped && gap_open));
    assign acc_eff = s_first ? !dropped : acc_reg;
    assign off_eff = s_first ? '0 : off_reg;
    assign wr_en   = acc_eff && (off_eff < len_sat);

    assign sample_ext = {{SAMPLE_BITS{1'b0}}, s_sample};

    always_comb begin
        started_next = started_reg;
        newest_next  = newest_reg;
        acc_next     = acc_reg;
        off_next     = off_reg;
        if (accept && !is_get) begin
            if (s_first) begin
                started_next = 1'b1;
                acc_next     = !dropped;
                newest_next  = (!dropped && advance) ? end_ts : nst;
            end
            off_next = wr_en ? off_eff + 1'b1 : off_eff;
        end
    end

    always_comb begin
        c_ctl.op     = is_get ? tsr_pkg::OP_GET : tsr_pkg::OP_PUT;
        c_ctl.clr_en = !is_get && clr_en;
        c_ctl.wr_en  = !is_get && wr_en;
        c_ctl.win_en = started_reg;
        c_base       = is_get ? s_ts[AW-1:0] : nst[AW-1:0];
        c_waddr      = s_ts[AW-1:0] + AW'(off_eff);
        c_cnt        = gap_full ? (AW+1)'(RING_DEPTH) : {1'b0, gap[AW-1:0]};
        c_wdata      = sample_ext[SAMPLE_BITS-1:0];
        c_len        = len_sat;
        c_age        = newest_reg - s_ts - 32'd1;
        if (is_get) begin
            q_push = accept && (len_sat != '0);
        end else begin
            q_push = accept && (clr_en || wr_en);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            newest_reg  <= '0;
            acc_reg     <= 1'b0;
            off_reg     <= '0;
        end else begin
            started_reg <= started_next;
            newest_reg  <= newest_next;
            acc_reg     <= acc_next;
            off_reg     <= off_next;
        end
    end

endmodule

// ===== hw/rtl/tsr_back.sv =====
// ============================================================================
// tsr_back: ring memory executor
// Runs clear sweeps, sample writes and get reads against the ring memory
// and holds the outgoing sample beat.
// ============================================================================
module tsr_back #(
    parameter int RING_DEPTH  = tsr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = tsr_pkg::SAMPLE_BITS_DEF,
    parameter int AW          = $clog2(RING_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  tsr_pkg::cmd_ctl_t             c_ctl,
    input  logic [AW-1:0]                 c_base,
    input  logic [AW-1:0]                 c_waddr,
    input  logic [AW:0]                   c_cnt,
    input  logic [SAMPLE_BITS-1:0]        c_wdata,
    input  logic [tsr_pkg::LEN_W-1:0]     c_len,
    input  logic [tsr_pkg::TS_W-1:0]      c_age,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_sample_out,
    output logic                          m_last
);

    tsr_pkg::back_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0]      ring_mem [RING_DEPTH];

    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [AW:0]                 cnt_reg, cnt_next;
    logic [tsr_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [tsr_pkg::TS_W-1:0]    age_reg, age_next;
    logic                        win_en_reg, win_en_next;
    logic [AW-1:0]               waddr_reg, waddr_next;
    logic [SAMPLE_BITS-1:0]      wdata_reg, wdata_next;
    logic                        wr_pend_reg, wr_pend_next;

    logic                        rd_valid_reg, rd_valid_next;
    logic                        rd_win_reg;
    logic                        rd_last_reg;
    logic [SAMPLE_BITS-1:0]      rd_data_reg;
    logic [SAMPLE_BITS+15:0]     rd_ext;

    logic                        out_free;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [SAMPLE_BITS-1:0]      mem_wdata;
    logic                        rd_en;

    assign out_free = !rd_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsr_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (c_ctl.op == tsr_pkg::OP_GET) begin
                        state_next = tsr_pkg::ST_GET;
                    end else if (c_ctl.clr_en) begin
                        state_next = tsr_pkg::ST_CLEAR;
                    end
                end
            end
            tsr_pkg::ST_CLEAR: begin
                if (cnt_reg == (AW+1)'(1)) begin
                    state_next = wr_pend_reg ? tsr_pkg::ST_WRITE : tsr_pkg::ST_IDLE;
                end
            end
            tsr_pkg::ST_WRITE: begin
                state_next = tsr_pkg::ST_IDLE;
            end
            tsr_pkg::ST_GET: begin
                if (out_free && rem_reg == tsr_pkg::LEN_W'(1)) begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = '0;
        rd_en        = 1'b0;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        age_next     = age_reg;
        win_en_next  = win_en_reg;
        waddr_next   = waddr_reg;
        wdata_next   = wdata_reg;
        wr_pend_next = wr_pend_reg;
        case (state_reg)
            tsr_pkg::ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    if (c_ctl.op == tsr_pkg::OP_GET) begin
                        ptr_next    = c_base;
                        rem_next    = c_len;
                        age_next    = c_age;
                        win_en_next = c_ctl.win_en;
                    end else if (c_ctl.clr_en) begin
                        ptr_next     = c_base;
                        cnt_next     = c_cnt;
                        waddr_next   = c_waddr;
                        wdata_next   = c_wdata;
                        wr_pend_next = c_ctl.wr_en;
                    end else begin
                        mem_we    = c_ctl.wr_en;
                        mem_waddr = c_waddr;
                        mem_wdata = c_wdata;
                    end
                end
            end
            tsr_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
            end
            tsr_pkg::ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = waddr_reg;
                mem_wdata = wdata_reg;
            end
            tsr_pkg::ST_GET: begin
                if (out_free) begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                    age_next = age_reg - 32'd1;
                    rem_next = rem_reg - 1'b1;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (rd_en) begin
            rd_valid_next = 1'b1;
        end else if (m_ready) begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsr_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        age_reg     <= age_next;
        win_en_reg  <= win_en_next;
        waddr_reg   <= waddr_next;
        wdata_reg   <= wdata_next;
        wr_pend_reg <= wr_pend_next;
        if (rd_en) begin
            // The age counter holds distance minus one, so the window test is
            // a check that the bits above the ring index are all zero.
            rd_win_reg  <= win_en_reg && (age_reg[tsr_pkg::TS_W-1:AW] == '0);
            rd_last_reg <= (rem_reg == tsr_pkg::LEN_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[ptr_reg];
        end
    end

    assign rd_ext       = {{16{1'b0}}, rd_data_reg};
    assign m_valid      = rd_valid_reg;
    assign m_sample_out = rd_win_reg ? signed'(rd_ext[15:0]) : '0;
    assign m_last       = rd_last_reg;

endmodule
